// File: src/jsf_pkg.sv
// ----------------------------------------------------------------------------
// jsf_pkg: shared types and constants for the JSON object stream framer
// Frame size, character codes, status and byte class codes, queue entry type.
// ----------------------------------------------------------------------------
package jsf_pkg;

	// frame storage size and derived counter widths
	localparam int FRAME_BYTES = 1024;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam int DEPTH_W     = CNT_W + 1;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int OUT_CNT_W = 10;
	localparam int TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	// request kinds
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// character codes
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE       = 3'd0,
		ST_STORED     = 3'd1,
		ST_DONE       = 3'd2,
		ST_LINEBREAK  = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_UNBALANCED = 3'd5,
		ST_TIMEOUT    = 3'd6
	} status_t;

	// request class decided by the front
	typedef enum logic [2:0] {
		CLS_TICK,
		CLS_LINEBREAK,
		CLS_BSLASH,
		CLS_QUOTE,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OTHER
	} byte_class_t;

	typedef struct packed {
		byte_class_t       cls;
		logic [BYTE_W-1:0] data;
	} jsf_item_t;

	// head of the queue as seen by the back
	typedef struct packed {
		logic      valid;
		jsf_item_t item;
	} jsf_head_t;

endpackage

// File: src/jsf_in_if.sv
// ----------------------------------------------------------------------------
// jsf_in_if: request channel of the framer
// Carries a byte or tick request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface jsf_in_if
	import jsf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: src/jsf_out_if.sv
// ----------------------------------------------------------------------------
// jsf_out_if: result channel of the framer
// Carries status, echoed byte, offset and frame length with valid/ready.
// ----------------------------------------------------------------------------
interface jsf_out_if
	import jsf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [BYTE_W-1:0]    echo_byte;
	logic [OUT_CNT_W-1:0] byte_offset;
	logic [OUT_CNT_W-1:0] frame_length;

	modport source (output valid, output status, output echo_byte, output byte_offset,
		output frame_length, input ready);
	modport sink   (input valid, input status, input echo_byte, input byte_offset,
		input frame_length, output ready);
endinterface

// File: src/jsf_front.sv
// ----------------------------------------------------------------------------
// jsf_front: request acceptance and byte classification
// Takes requests while the queue has room and tags each with its class.
// ----------------------------------------------------------------------------
module jsf_front
	import jsf_pkg::*;
(
	jsf_in_if.sink    in_ch,
	input  logic      q_full,
	output logic      push,
	output jsf_item_t push_item
);

	// handshake: accept whenever the queue has a free slot
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	// classify the request
	always_comb begin
		push_item.data = in_ch.rx_byte;
		if (in_ch.action == ACT_TICK) begin
			push_item.cls = CLS_TICK;
		end else if (in_ch.rx_byte == CH_LF || in_ch.rx_byte == CH_CR) begin
			push_item.cls = CLS_LINEBREAK;
		end else if (in_ch.rx_byte == CH_BSLASH) begin
			push_item.cls = CLS_BSLASH;
		end else if (in_ch.rx_byte == CH_QUOTE) begin
			push_item.cls = CLS_QUOTE;
		end else if (in_ch.rx_byte == CH_OPEN) begin
			push_item.cls = CLS_OPEN;
		end else if (in_ch.rx_byte == CH_CLOSE) begin
			push_item.cls = CLS_CLOSE;
		end else begin
			push_item.cls = CLS_OTHER;
		end
	end

endmodule

// File: src/jsf_queue.sv
// ----------------------------------------------------------------------------
// jsf_queue: short FIFO between front and back
// Two entries, so front and back stall independently at full rate.
// ----------------------------------------------------------------------------
module jsf_queue
	import jsf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  jsf_item_t push_item,
	input  logic      pop,
	output logic      full,
	output jsf_head_t head
);

	jsf_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: src/jsf_back.sv
// ----------------------------------------------------------------------------
// jsf_back: frame state update and result register
// Applies one classified request per cycle to the frame state while the
// result slot is free or drained; holds results until downstream takes them.
// ----------------------------------------------------------------------------
module jsf_back
	import jsf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TIMEOUT_W-1:0] idle_timeout,
	input  jsf_head_t            head,
	output logic                 pop,
	jsf_out_if.source            out_ch
);

	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(FRAME_BYTES - 1);

	// frame state
	logic [CNT_W-1:0]          fill_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic                      in_str_q;
	logic                      esc_q;
	logic [TIMEOUT_W-1:0]      idle_q;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [BYTE_W-1:0]    echo_q;
	logic [OUT_CNT_W-1:0] offset_q;
	logic [OUT_CNT_W-1:0] length_q;

	// next values
	logic [CNT_W-1:0]          fill_d;
	logic signed [DEPTH_W-1:0] depth_d;
	logic                      in_str_d;
	logic                      esc_d;
	logic [TIMEOUT_W-1:0]      idle_d;
	status_t                   status_d;
	logic [BYTE_W-1:0]         echo_d;
	logic [CNT_W-1:0]          offset_d;
	logic [CNT_W-1:0]          length_d;
	logic [CNT_W-1:0]          fill_inc;
	logic signed [DEPTH_W-1:0] depth_dec;
	logic                      clear;

	// take the next request when the result slot is free or being drained
	assign pop = head.valid && (!out_valid_q || out_ch.ready);

	assign fill_inc  = fill_q + CNT_W'(1);
	assign depth_dec = depth_q - DEPTH_W'(1);

	// frame state transition
	always_comb begin
		fill_d   = fill_q;
		depth_d  = depth_q;
		in_str_d = in_str_q;
		esc_d    = esc_q;
		idle_d   = idle_q;
		status_d = ST_STORED;
		echo_d   = head.item.data;
		offset_d = '0;
		length_d = '0;
		clear    = 1'b0;
		if (head.item.cls == CLS_TICK) begin
			echo_d = '0;
			if (fill_q == '0) begin
				status_d = ST_IDLE;
			end else if (idle_q >= idle_timeout) begin
				status_d = ST_TIMEOUT;
				clear    = 1'b1;
			end else begin
				idle_d   = idle_q + TIMEOUT_W'(1);
				status_d = ST_IDLE;
				length_d = fill_q;
			end
		end else begin
			idle_d = '0;
			if (head.item.cls == CLS_LINEBREAK) begin
				status_d = ST_LINEBREAK;
				clear    = 1'b1;
			end else if (fill_q >= FILL_MAX) begin
				status_d = ST_OVERFLOW;
				clear    = 1'b1;
			end else begin
				offset_d = fill_q;
				fill_d   = fill_inc;
				length_d = fill_inc;
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (head.item.cls == CLS_BSLASH) begin
					esc_d = 1'b1;
				end else if (head.item.cls == CLS_QUOTE) begin
					in_str_d = !in_str_q;
				end else if (!in_str_q && head.item.cls == CLS_OPEN) begin
					depth_d = depth_q + DEPTH_W'(1);
				end else if (!in_str_q && head.item.cls == CLS_CLOSE) begin
					depth_d = depth_dec;
					if (depth_dec == '0) begin
						status_d = ST_DONE;
						clear    = 1'b1;
					end else if (depth_dec[DEPTH_W-1]) begin
						status_d = ST_UNBALANCED;
						length_d = '0;
						clear    = 1'b1;
					end
				end
			end
		end
		if (clear) begin
			fill_d   = '0;
			depth_d  = '0;
			in_str_d = 1'b0;
			esc_d    = 1'b0;
			idle_d   = '0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			depth_q  <= '0;
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			idle_q   <= '0;
		end else if (pop) begin
			fill_q   <= fill_d;
			depth_q  <= depth_d;
			in_str_q <= in_str_d;
			esc_q    <= esc_d;
			idle_q   <= idle_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_d;
			echo_q   <= echo_d;
			offset_q <= OUT_CNT_W'(offset_d);
			length_q <= OUT_CNT_W'(length_d);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.echo_byte    = echo_q;
	assign out_ch.byte_offset  = offset_q;
	assign out_ch.frame_length = length_q;

endmodule

// File: src/json_object_stream_framer.sv
// ----------------------------------------------------------------------------
// json_object_stream_framer: finds the ends of JSON objects in a byte stream
// Counts braces outside strings, tracks escapes, clears the frame on object end,
// line breaks, overflow, unmatched close and idle timeout.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      action, rx_byte
//  out_ch    out   valid / ready      status, echo_byte, byte_offset, frame_length
//  cfg       in    cfg_we             cfg_wdata (idle timeout in ticks)
//
//  One request per cycle sustained while results are taken; an accepted
//  request passes through the queue slot, then the result register.
//  The frame state update in the back stage is the one loop, closed through its registers.
//  Reset clears the frame state and sets the idle timeout to 1000 ticks.
//  A two-entry queue lets requests keep arriving while a result is stalled.
// ----------------------------------------------------------------------------
module json_object_stream_framer
	import jsf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	jsf_in_if.sink               in_ch,
	jsf_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata
);

	logic [TIMEOUT_W-1:0] idle_timeout_q;
	logic                 q_full;
	logic                 push;
	logic                 pop;
	jsf_item_t            push_item;
	jsf_head_t            q_head;

	// idle timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			idle_timeout_q <= cfg_wdata;
		end
	end

	jsf_front u_front (
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	jsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (q_head)
	);

	jsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.idle_timeout (idle_timeout_q),
		.head         (q_head),
		.pop          (pop),
		.out_ch       (out_ch)
	);

	// an accepted request is waiting in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> q_head.valid)
		else $error("accepted request missing from queue");

	// a stored byte reports a length one past its offset
	a_stored_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_STORED
		|-> out_ch.frame_length == out_ch.byte_offset + OUT_CNT_W'(1))
		else $error("stored byte length mismatch");

	// an object end is a closing brace and its length covers it
	a_done_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_DONE
		|-> out_ch.echo_byte == CH_CLOSE
			&& out_ch.frame_length == out_ch.byte_offset + OUT_CNT_W'(1))
		else $error("object end without closing brace");

	// a line break clear carries a line break byte and no offset or length
	a_linebreak: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_LINEBREAK
		|-> (out_ch.echo_byte == CH_LF || out_ch.echo_byte == CH_CR)
			&& out_ch.byte_offset == '0 && out_ch.frame_length == '0)
		else $error("line break result malformed");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the JSON object stream framer
// Sends byte and tick requests through a queue-fed driver, predicts every
// result from a local model of the frame state, and checks each result in
// order as it is accepted. Phases change the idle timeout between drains.
// ----------------------------------------------------------------------------
module tb_top;
	import jsf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int GAP_PCT     = 14;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] data;
	} framer_req_t;

	typedef struct packed {
		status_t              status;
		logic [BYTE_W-1:0]    echo;
		logic [OUT_CNT_W-1:0] offset;
		logic [OUT_CNT_W-1:0] length;
	} framer_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	jsf_in_if  in_ch ();
	jsf_out_if out_ch ();

	json_object_stream_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	framer_req_t    pending_reqs[$];
	framer_result_t expected_results[$];
	int             pushed_count = 0;
	int             fail_count   = 0;
	int             stall_cycles = 0;
	bit             steady       = 1'b0;

	// local copy of the frame state
	int                   frame_fill  = 0;
	int                   frame_depth = 0;
	bit                   in_quotes   = 1'b0;
	bit                   escaped     = 1'b0;
	logic [TIMEOUT_W-1:0] quiet_ticks   = '0;
	logic [TIMEOUT_W-1:0] timeout_limit = TIMEOUT_RESET;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void clear_frame();
		frame_fill  = 0;
		frame_depth = 0;
		in_quotes   = 1'b0;
		escaped     = 1'b0;
		quiet_ticks = '0;
	endfunction

	function automatic framer_result_t make_result(status_t st, logic [BYTE_W-1:0] b,
		int off, int len);
		framer_result_t r;
		r.status = st;
		r.echo   = b;
		r.offset = off[OUT_CNT_W-1:0];
		r.length = len[OUT_CNT_W-1:0];
		return r;
	endfunction

	// next frame state and the result for one accepted request
	function automatic framer_result_t frame_step(framer_req_t req);
		logic [BYTE_W-1:0] c;
		int                off;
		int                len;
		c = req.data;
		if (req.action == ACT_TICK) begin
			if (frame_fill == 0)
				return make_result(ST_IDLE, '0, 0, 0);
			if (quiet_ticks >= timeout_limit) begin
				clear_frame();
				return make_result(ST_TIMEOUT, '0, 0, 0);
			end
			quiet_ticks = quiet_ticks + 1'b1;
			return make_result(ST_IDLE, '0, 0, frame_fill);
		end

		quiet_ticks = '0;
		if (c == CH_LF || c == CH_CR) begin
			clear_frame();
			return make_result(ST_LINEBREAK, c, 0, 0);
		end
		if (frame_fill >= FRAME_BYTES - 1) begin
			clear_frame();
			return make_result(ST_OVERFLOW, c, 0, 0);
		end

		off        = frame_fill;
		frame_fill = frame_fill + 1;
		if (escaped) begin
			escaped = 1'b0;
		end else if (c == CH_BSLASH) begin
			escaped = 1'b1;
		end else if (c == CH_QUOTE) begin
			in_quotes = !in_quotes;
		end else if (!in_quotes) begin
			if (c == CH_OPEN) begin
				frame_depth++;
			end else if (c == CH_CLOSE) begin
				frame_depth--;
				if (frame_depth == 0) begin
					len = frame_fill;
					clear_frame();
					return make_result(ST_DONE, c, off, len);
				end
				if (frame_depth < 0) begin
					clear_frame();
					return make_result(ST_UNBALANCED, c, off, 0);
				end
			end
		end
		return make_result(ST_STORED, c, off, frame_fill);
	endfunction

	// request driver: holds valid until accepted, random gaps otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.action  <= ACT_BYTE;
			in_ch.rx_byte <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(frame_step(pending_reqs.pop_front()));
			if (in_ch.valid && !in_ch.ready) begin
				// request still waiting, keep it on the bus
			end else if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT))
			begin
				in_ch.valid   <= 1'b1;
				in_ch.action  <= pending_reqs[0].action;
				in_ch.rx_byte <= pending_reqs[0].data;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	task automatic check_result();
		framer_result_t want;
		if (expected_results.size() == 0) begin
			$error("result with nothing expected: status %0d byte %0h", out_ch.status,
				out_ch.echo_byte);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		if (out_ch.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, out_ch.status);
			fail_count++;
		end
		if (out_ch.echo_byte !== want.echo) begin
			$error("echo_byte: expected %0h, got %0h", want.echo, out_ch.echo_byte);
			fail_count++;
		end
		if (out_ch.byte_offset !== want.offset) begin
			$error("byte_offset: expected %0d, got %0d", want.offset, out_ch.byte_offset);
			fail_count++;
		end
		if (out_ch.frame_length !== want.length) begin
			$error("frame_length: expected %0d, got %0d", want.length, out_ch.frame_length);
			fail_count++;
		end
	endtask

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			out_ch.ready <= steady || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// request generation
	// ------------------------------------------------------------------
	task automatic add_req(logic act, logic [BYTE_W-1:0] b);
		framer_req_t r;
		r.action = act;
		r.data   = b;
		pending_reqs.push_back(r);
		pushed_count++;
	endtask

	task automatic add_byte(logic [BYTE_W-1:0] b);
		add_req(ACT_BYTE, b);
	endtask

	// rx_byte is don't-care on ticks, so keep it random
	task automatic add_tick();
		add_req(ACT_TICK, BYTE_W'($urandom_range(255)));
	endtask

	task automatic maybe_tick();
		if ($urandom_range(7) == 0)
			add_tick();
	endtask

	// any byte that does not end or escape a string
	function automatic logic [BYTE_W-1:0] text_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(255));
		while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF || b == CH_CR);
		return b;
	endfunction

	// a byte with no framing meaning at all
	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do
			b = text_byte();
		while (b == CH_OPEN || b == CH_CLOSE);
		return b;
	endfunction

	task automatic add_string();
		int n;
		n = $urandom_range(4);
		add_byte(CH_QUOTE);
		repeat (n) begin
			if ($urandom_range(5) == 0) begin
				add_byte(CH_BSLASH);
				case ($urandom_range(2))
					0: add_byte(CH_QUOTE);
					1: add_byte(CH_BSLASH);
					default: add_byte(text_byte());
				endcase
			end else begin
				add_byte(text_byte());
			end
			maybe_tick();
		end
		add_byte(CH_QUOTE);
	endtask

	task automatic add_members(int n);
		repeat (n) begin
			add_string();
			add_byte(8'h3A);
			if ($urandom_range(1) == 0)
				add_string();
			else
				repeat ($urandom_range(1, 3)) add_byte(BYTE_W'(8'h30 + $urandom_range(9)));
			add_byte(8'h2C);
			maybe_tick();
		end
	endtask

	// well-formed object, nested up to three levels
	task automatic add_object();
		int levels;
		levels = $urandom_range(1, 3);
		for (int l = 0; l < levels; l++) begin
			add_byte(CH_OPEN);
			add_members($urandom_range(2));
			if (l + 1 < levels) begin
				add_string();
				add_byte(8'h3A);
			end
		end
		for (int l = 0; l < levels; l++) begin
			if ($urandom_range(2) == 0)
				add_members(1);
			add_byte(CH_CLOSE);
			maybe_tick();
		end
	endtask

	task automatic add_noise();
		case ($urandom_range(4))
			0: repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(255)));
			1: add_byte($urandom_range(1) ? CH_LF : CH_CR);
			2: add_byte(CH_CLOSE);
			3: repeat ($urandom_range(1, 5)) add_tick();
			default: begin
				// object that never closes
				add_byte(CH_OPEN);
				add_byte(CH_QUOTE);
				repeat ($urandom_range(3)) add_byte(text_byte());
			end
		endcase
	endtask

	task automatic add_random(int count);
		int start;
		start = pushed_count;
		while (pushed_count - start < count) begin
			if ($urandom_range(99) < 75)
				add_object();
			else
				add_noise();
		end
	endtask

	// sender holds off until every expected result is back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timeout(logic [TIMEOUT_W-1:0] ticks);
		@(posedge clk);
		cfg_we        <= 1'b1;
		cfg_wdata     <= ticks;
		timeout_limit = ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		@(posedge arst_n);
		@(negedge clk);

		// directed: escaped quote, braces in strings, line breaks, bad closes
		add_req(ACT_TICK, 8'hFF);
		add_byte(CH_OPEN);
		add_byte(CH_QUOTE);
		add_byte(8'h00);
		add_byte(CH_BSLASH);
		add_byte(CH_QUOTE);
		add_byte(CH_CLOSE);
		add_byte(CH_QUOTE);
		add_req(ACT_TICK, 8'h00);
		add_byte(CH_CLOSE);
		add_byte(CH_CLOSE);
		add_byte(CH_BSLASH);
		add_byte(CH_CLOSE);
		add_byte(CH_CLOSE);
		add_byte(CH_OPEN);
		add_byte(CH_QUOTE);
		add_byte(CH_BSLASH);
		add_byte(CH_LF);
		add_byte(CH_OPEN);
		add_byte(8'hFF);
		add_byte(CH_CR);
		add_byte(CH_OPEN);
		add_byte(CH_OPEN);
		add_byte(CH_CLOSE);
		add_byte(CH_CLOSE);
		wait_drained();

		// zero timeout: first tick on a started frame expires it
		set_timeout(16'd0);
		add_byte(CH_OPEN);
		add_tick();
		add_tick();
		wait_drained();

		// timeout of one tick, then random traffic
		set_timeout(16'd1);
		add_byte(CH_OPEN);
		add_tick();
		add_tick();
		add_random(100);
		wait_drained();

		// no gaps on either side for a while
		set_timeout(16'd3);
		steady = 1'b1;
		add_random(120);
		wait_drained();
		steady = 1'b0;

		// longest timeout; fill the frame to the last slot, then overflow
		set_timeout(16'hFFFF);
		add_byte(CH_OPEN);
		for (int i = 1; i < FRAME_BYTES - 1; i++) begin
			if ($urandom_range(3) == 0)
				add_byte(CH_OPEN);
			else
				add_byte(plain_byte());
			if (i % 200 == 0)
				add_tick();
		end
		add_byte(plain_byte());
		add_tick();
		add_byte(CH_LF);
		wait_drained();

		set_timeout(16'd2);
		add_random(180);
		wait_drained();

		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
